// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the frame receiver rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// shared types, constants and helpers of the fixed frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package ufr_pkg;

	localparam int PAYLOAD_BYTES = 96;

	// record storage: two banks of PAYLOAD_BYTES, one committed, one receiving
	localparam int REC_DEPTH = 2 * PAYLOAD_BYTES;
	localparam int REC_AW    = $clog2(REC_DEPTH);

	// frame position runs 0 .. PAYLOAD_BYTES + 3
	localparam int POS_W = $clog2(PAYLOAD_BYTES + 4);

	localparam int BYTE_W   = 8;
	localparam int IDX_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [POS_W-1:0] POS_SYNC_A = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC_B = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA0  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CHK_A  = POS_W'(PAYLOAD_BYTES + 2);
	localparam logic [POS_W-1:0] POS_CHK_B  = POS_W'(PAYLOAD_BYTES + 3);

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_REJECT = 2'd2,
		EV_READ   = 2'd3
	} ufr_event_t;

	// one classified beat, handed from front to back
	typedef struct packed {
		ufr_event_t              evt;
		logic                    have_record;
		logic                    wr_en;
		logic                    rd_en;
		logic [REC_AW-1:0]       addr;
		logic [BYTE_W-1:0]       data;
	} ufr_cmd_t;

	function automatic logic [REC_AW-1:0] rec_addr(input logic bank,
		input logic [IDX_W-1:0] idx);
		logic [REC_AW-1:0] base;
		base = bank ? REC_AW'(PAYLOAD_BYTES) : REC_AW'(0);
		return base + REC_AW'(idx);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ubx_fixed_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// ubx_fixed_frame_receiver_top
// fixed length sync framed record receiver with fletcher-8 check
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: op; tdata: rx_byte, read_index
//  m_*       out  m_tvalid/m_tready   tuser: event_res; tdata: read_data, have_record
//  cfg_*     in   cfg_we              cfg_index selects register, cfg_data value
//
//  one beat per cycle sustained while m_tready keeps up; a result beat is registered
//  in the queue and then in the result register before it is presented
//  the front keeps frame position and sums, a two entry queue feeds the back,
//  which owns the record ram (one access per beat) and the result register
//  the record ram is two banks, committing a frame just swaps the bank pointer
//  arst_n clears control state only; ram contents are undefined until written
//  s_tready drops only when the queue is full, i.e. after m_tready stalls
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ubx_fixed_frame_receiver_top
	import ufr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	// input beats
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [15:0]          s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
	input  wire logic                 s_tuser,   // [0] op
	// result beats
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [15:0]          m_tdata,   // [7:0] read_data, [8] have_record, rest zero
	output      logic [1:0]           m_tuser    // [1:0] event_res
);

	logic       push;
	logic       q_full;
	logic       q_valid;
	logic       pop;
	ufr_cmd_t   front_cmd;
	ufr_cmd_t   back_cmd;
	ufr_event_t out_evt;
	logic [BYTE_W-1:0] out_data;
	logic       out_have;

	assign s_tready = !q_full;

	// front: frame hunt, checksum and classification
	ufr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_byte   (s_tdata[7:0]),
		.in_index  (s_tdata[14:8]),
		.push      (push),
		.cmd       (front_cmd)
	);

	// short queue decoupling front from back
	ufr_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_cmd  (back_cmd)
	);

	// back: record ram and result register
	ufr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_evt   (out_evt),
		.out_data  (out_data),
		.out_have  (out_have)
	);

	assign m_tuser = out_evt;
	assign m_tdata = {7'd0, out_have, out_data};

	// a frame accept always reports a held record
	`ASSERT_IMPLY(a_accept_has_record, clk, arst_n, m_tvalid && (m_tuser == EV_ACCEPT), m_tdata[8])
	// only read results carry data
	`ASSERT_IMPLY(a_data_only_on_read, clk, arst_n, m_tvalid && (m_tuser != EV_READ), m_tdata[7:0] == 8'd0)
	// no record means nothing can be read back
	`ASSERT_IMPLY(a_no_record_no_data, clk, arst_n, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'd0)
	// the queue never takes a beat while full
	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && q_full)

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_ram.sv =====
// ----------------------------------------------------------------------------
// ufr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_front.sv =====
// ----------------------------------------------------------------------------
// ufr_front
// frame hunt, fletcher sums and beat classification into store commands
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_front
	import ufr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic                 in_op,
	input  wire logic [BYTE_W-1:0]    in_byte,
	input  wire logic [IDX_W-1:0]     in_index,
	output      logic                 push,
	output      ufr_cmd_t             cmd
);

	logic [BYTE_W-1:0] sync_first_q, sync_second_q;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic              bank_q, bank_d;   // bank holding the committed record
	logic              have_q, have_d;
	logic [BYTE_W-1:0] want;
	logic [BYTE_W-1:0] sum_a_inc;
	logic [IDX_W-1:0]  wr_idx;

	assign push      = in_valid && in_ready;
	assign want      = (pos_q == POS_SYNC_A) ? sync_first_q : sync_second_q;
	assign sum_a_inc = sum_a_q + in_byte;
	assign wr_idx    = IDX_W'(pos_q - POS_DATA0);

	always_comb begin
		pos_d     = pos_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		bank_d    = bank_q;
		have_d    = have_q;
		cmd.evt   = EV_NONE;
		cmd.wr_en = 1'b0;
		cmd.rd_en = 1'b0;
		cmd.addr  = rec_addr(!bank_q, wr_idx);
		cmd.data  = in_byte;
		if (in_op == OP_READ) begin
			cmd.evt   = EV_READ;
			cmd.rd_en = have_q && (in_index < IDX_W'(PAYLOAD_BYTES));
			cmd.addr  = rec_addr(bank_q, in_index);
		end else begin
			priority if (pos_q < POS_DATA0) begin
				if (in_byte == want) begin
					pos_d = pos_q + POS_W'(1);
					if (pos_q == POS_SYNC_B) begin
						sum_a_d = '0;
						sum_b_d = '0;
					end
				end else begin
					pos_d = POS_SYNC_A;
				end
			end else if (pos_q < POS_CHK_A) begin
				cmd.wr_en = 1'b1;
				sum_a_d   = sum_a_inc;
				sum_b_d   = sum_b_q + sum_a_inc;
				pos_d     = pos_q + POS_W'(1);
			end else if (pos_q == POS_CHK_A) begin
				if (in_byte != sum_a_q) begin
					pos_d   = POS_SYNC_A;
					cmd.evt = EV_REJECT;
				end else begin
					pos_d = POS_CHK_B;
				end
			end else if (pos_q == POS_CHK_B) begin
				pos_d = POS_SYNC_A;
				if (in_byte == sum_b_q) begin
					// swap banks: the freshly filled one becomes committed
					bank_d  = !bank_q;
					have_d  = 1'b1;
					cmd.evt = EV_ACCEPT;
				end else begin
					cmd.evt = EV_REJECT;
				end
			end else begin
				pos_d = POS_SYNC_A;
			end
		end
		cmd.have_record = have_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			pos_q         <= POS_SYNC_A;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
			bank_q        <= 1'b0;
			have_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
					REG_SYNC_SECOND: sync_second_q <= cfg_data;
					default: ;
				endcase
			end
			if (push) begin
				pos_q   <= pos_d;
				sum_a_q <= sum_a_d;
				sum_b_q <= sum_b_d;
				bank_q  <= bank_d;
				have_q  <= have_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ufr_cmd_fifo
// two entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_cmd_fifo
	import ufr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ufr_cmd_t push_cmd,
	output      logic     full,
	input  wire logic     pop,
	output      logic     valid,
	output      ufr_cmd_t pop_cmd
);

	ufr_cmd_t   entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_back.sv =====
// ----------------------------------------------------------------------------
// ufr_back
// record store access and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module ufr_back
	import ufr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire ufr_cmd_t          cmd,
	output      logic              pop,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      ufr_event_t        out_evt,
	output      logic [BYTE_W-1:0] out_data,
	output      logic              out_have
);

	logic              out_valid_q;
	ufr_event_t        evt_s2;
	logic              have_s2;
	logic              rd_s2;
	logic [BYTE_W-1:0] ram_rdata;

	// the ram read register only loads on a pop, so it holds through a stall
	assign pop = cmd_valid && (!out_valid_q || out_ready);

	ufr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (REC_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (pop && cmd.wr_en),
		.waddr (cmd.addr),
		.wdata (cmd.data),
		.re    (pop && cmd.rd_en),
		.raddr (cmd.addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			evt_s2  <= cmd.evt;
			have_s2 <= cmd.have_record;
			rd_s2   <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_evt   = evt_s2;
	assign out_data  = rd_s2 ? ram_rdata : '0;
	assign out_have  = have_s2;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fixed frame receiver with fletcher-8 check
//
// beats go in on the s_* stream and results come back on the m_* stream
// a local predictor tracks the header hunt, the running check pair and the
// committed record, and queues one expected result per accepted input beat
// every result beat is compared field by field against the oldest entry
// traffic is mostly well formed frames with random payload, mixed with read
// bursts, noise and bad check bytes, under several header settings, with
// random gaps on both sides, one long output hold-off and a full rate tail
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import ufr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 8;
	// pause before a register write, after the results have drained
	localparam int CFG_SETTLE = 4;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CK_A,
		FRAME_BAD_CK_B
	} frame_fault_t;

	// one expected result beat
	typedef struct {
		ufr_event_t        evt;
		logic [BYTE_W-1:0] data;
		logic              have;
	} beat_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [7:0] rx_byte, [14:8] read_index, [15] zero
	logic                 s_tuser;   // [0] op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // [7:0] read_data, [8] have_record, rest zero
	logic [1:0]           m_tuser;   // [1:0] event_res

	// predictor state: header bytes, position, check pair and the two stores
	logic [BYTE_W-1:0] hdr_first;
	logic [BYTE_W-1:0] hdr_second;
	logic [POS_W-1:0]  frm_pos;
	logic [BYTE_W-1:0] fl_a;
	logic [BYTE_W-1:0] fl_b;
	logic [BYTE_W-1:0] rx_buf [PAYLOAD_BYTES];
	logic [BYTE_W-1:0] rec_buf [PAYLOAD_BYTES];
	logic              rec_valid;

	beat_result_t pending_results [$];
	beat_result_t oldest;

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  beats_sent = 0;
	// pacing controls shared by the test tasks and the input and output sides
	bit  src_idle_en = 1'b0;
	bit  sink_stall_en = 1'b0;
	bit  hold_request = 1'b0;

	ubx_fixed_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// watchdog, counts every cycle of the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// expected result of one input beat, advances the local frame state
	function automatic beat_result_t predict_beat(input logic op,
		input logic [BYTE_W-1:0] rx, input logic [IDX_W-1:0] idx);
		beat_result_t r;
		r.evt = EV_NONE;
		r.data = '0;
		if (op == OP_READ) begin
			r.evt = EV_READ;
			// nothing committed yet or index past the record reads as zero
			if (rec_valid && idx < PAYLOAD_BYTES)
				r.data = rec_buf[idx];
		end else if (frm_pos == POS_SYNC_A || frm_pos == POS_SYNC_B) begin
			// header hunt, a mismatch starts over without a retry of the byte
			if (rx == ((frm_pos == POS_SYNC_A) ? hdr_first : hdr_second)) begin
				frm_pos = frm_pos + 1'b1;
				if (frm_pos == POS_DATA0) begin
					fl_a = '0;
					fl_b = '0;
				end
			end else begin
				frm_pos = POS_SYNC_A;
			end
		end else if (frm_pos < POS_CHK_A) begin
			rx_buf[frm_pos - POS_DATA0] = rx;
			fl_a = fl_a + rx;
			fl_b = fl_b + fl_a;
			frm_pos = frm_pos + 1'b1;
		end else if (frm_pos == POS_CHK_A) begin
			// bad first check byte drops the frame at once
			if (rx != fl_a) begin
				frm_pos = POS_SYNC_A;
				r.evt = EV_REJECT;
			end else begin
				frm_pos = frm_pos + 1'b1;
			end
		end else if (frm_pos == POS_CHK_B) begin
			frm_pos = POS_SYNC_A;
			if (rx == fl_b) begin
				rec_buf = rx_buf;
				rec_valid = 1'b1;
				r.evt = EV_ACCEPT;
			end else begin
				r.evt = EV_REJECT;
			end
		end else begin
			frm_pos = POS_SYNC_A;
		end
		r.have = rec_valid;
		return r;
	endfunction

	// random byte, now and then an extreme or one of the header values
	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hFF;
			2: return hdr_first;
			3: return hdr_second;
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------

	// offer one beat, with an optional random gap, and record its result
	task automatic send_beat(input logic op, input logic [BYTE_W-1:0] rx,
		input logic [IDX_W-1:0] idx);
		int gap;
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, idx, rx};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(predict_beat(op, rx, idx));
		beats_sent++;
	endtask

	// unused field carries random bits so every input bit but the zero bit 15 toggles
	task automatic send_rx(input logic [BYTE_W-1:0] rx);
		send_beat(OP_RX, rx, IDX_W'($urandom));
	endtask

	task automatic send_read(input logic [IDX_W-1:0] idx);
		send_beat(OP_READ, BYTE_W'($urandom), idx);
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// header, random payload with optional interleaved reads, check pair
	task automatic send_frame(input frame_fault_t fault, input int read_pct);
		logic [BYTE_W-1:0] ck_a;
		logic [BYTE_W-1:0] ck_b;
		logic [BYTE_W-1:0] b;
		send_rx(hdr_first);
		send_rx(hdr_second);
		ck_a = '0;
		ck_b = '0;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if ($urandom_range(0, 99) < read_pct)
				send_read(IDX_W'($urandom_range(0, 127)));
			b = rand_byte();
			ck_a = ck_a + b;
			ck_b = ck_b + ck_a;
			send_rx(b);
		end
		case (fault)
			FRAME_BAD_CK_A: begin
				send_rx(ck_a ^ BYTE_W'($urandom_range(1, 255)));
				// the would-be second check byte is now just a hunt byte
				send_rx(ck_b);
			end
			FRAME_BAD_CK_B: begin
				send_rx(ck_a);
				send_rx(ck_b ^ BYTE_W'($urandom_range(1, 255)));
			end
			default: begin
				send_rx(ck_a);
				send_rx(ck_b);
			end
		endcase
	endtask

	task automatic read_burst(input int n);
		for (int i = 0; i < n; i++)
			send_read(IDX_W'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 127 : 95)));
	endtask

	task automatic noise_burst(input int n);
		for (int i = 0; i < n; i++)
			send_rx(rand_byte());
	endtask

	// header registers change only with the block drained
	task automatic write_sync(input logic [BYTE_W-1:0] first,
		input logic [BYTE_W-1:0] second);
		idle_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data <= first;
		@(negedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_data <= second;
		@(negedge clk);
		cfg_we <= 1'b0;
		hdr_first = first;
		hdr_second = second;
	endtask

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------

	// ready pacing: random bursts of stall and accept, or one long hold-off
	initial begin : sink_pacing
		int   run_left;
		int   hold_left;
		logic level;
		run_left = 0;
		hold_left = 0;
		level = 1'b1;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 8);
					level = !(sink_stall_en && $urandom_range(0, 2) == 0);
				end
				run_left--;
				m_tready <= sink_stall_en ? level : 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	// compare each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				oldest = pending_results.pop_front();
				if (m_tuser != oldest.evt)
					report_mismatch($sformatf("event_res got %0d want %0d",
						m_tuser, oldest.evt));
				if (m_tdata[7:0] != oldest.data)
					report_mismatch($sformatf("read_data got %02h want %02h",
						m_tdata[7:0], oldest.data));
				if (m_tdata[8] != oldest.have)
					report_mismatch($sformatf("have_record got %0b want %0b",
						m_tdata[8], oldest.have));
				if (m_tdata[15:9] != '0)
					report_mismatch($sformatf("tdata pad bits got %02h", m_tdata[15:9]));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reads before anything is committed, including indexes past the record
	task automatic test_reads_before_record();
		send_read(7'd0);
		send_read(7'd1);
		send_read(7'd95);
		send_read(7'd96);
		send_read(7'd127);
		send_read(7'h55);
		send_read(7'h2A);
	endtask

	// header hunt at reset values
	task automatic test_sync_hunt();
		// a second first-header byte breaks the hunt and is not retried,
		// so the following second-header byte finds position zero
		send_rx(SYNC_FIRST_RST);
		send_rx(SYNC_FIRST_RST);
		send_rx(SYNC_SECOND_RST);
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(SYNC_FIRST_RST);
		send_rx(8'h00);
	endtask

	task automatic test_frame_accept();
		send_frame(FRAME_GOOD, 0);
		send_read(7'd0);
		send_read(7'd95);
		send_read(7'd96);
		send_read(7'd127);
	endtask

	// bad first check, bad second check, committed record must survive both
	task automatic test_check_rejects();
		send_frame(FRAME_BAD_CK_A, 0);
		send_frame(FRAME_BAD_CK_B, 0);
		read_burst(8);
		send_frame(FRAME_GOOD, 0);
	endtask

	// reads interleaved heavily with a frame in progress
	task automatic test_reads_mid_frame();
		send_frame(FRAME_GOOD, 40);
		read_burst(6);
	endtask

	// extreme, equal and random header settings
	task automatic test_sync_settings();
		logic [BYTE_W-1:0] firsts [4];
		logic [BYTE_W-1:0] seconds [4];
		frame_fault_t      fault;
		firsts = '{8'h00, 8'hFF, 8'h5A, 8'($urandom)};
		seconds = '{8'hFF, 8'h00, 8'h5A, 8'($urandom)};
		for (int s = 0; s < 4; s++) begin
			write_sync(firsts[s], seconds[s]);
			send_frame(FRAME_GOOD, 5);
			noise_burst($urandom_range(1, 6));
			fault = frame_fault_t'($urandom_range(FRAME_GOOD, FRAME_BAD_CK_B));
			send_frame(fault, 5);
			read_burst(6);
		end
	endtask

	// mostly good frames, some with bad checks, plus noise and read bursts
	task automatic test_random_traffic(input int n);
		int stop;
		int kind;
		frame_fault_t fault;
		stop = beats_sent + n;
		while (beats_sent < stop) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				kind = $urandom_range(0, 99);
				fault = (kind < 70) ? FRAME_GOOD :
					(kind < 85) ? FRAME_BAD_CK_A : FRAME_BAD_CK_B;
				send_frame(fault, $urandom_range(0, 10));
			end else if (kind < 80) begin
				noise_burst($urandom_range(1, 12));
			end else begin
				read_burst($urandom_range(1, 12));
			end
		end
	endtask

	// output held off while input keeps coming, the block has to stall
	task automatic test_backpressure();
		src_idle_en = 1'b0;
		hold_request = 1'b1;
		send_frame(FRAME_GOOD, 10);
		read_burst(8);
		src_idle_en = 1'b1;
	endtask

	// closing stretch with no gaps on either side
	task automatic test_full_rate(input int n);
		src_idle_en = 1'b0;
		sink_stall_en = 1'b0;
		test_random_traffic(n);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SYNC_FIRST;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_RX;
		hdr_first = SYNC_FIRST_RST;
		hdr_second = SYNC_SECOND_RST;
		frm_pos = POS_SYNC_A;
		fl_a = '0;
		fl_b = '0;
		rec_valid = 1'b0;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			rx_buf[i] = '0;
			rec_buf[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_en = 1'b1;
		sink_stall_en = 1'b1;
		test_reads_before_record();
		test_sync_hunt();
		test_frame_accept();
		test_check_rejects();
		test_reads_mid_frame();
		test_sync_settings();
		write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
		test_random_traffic(100);
		write_sync(8'($urandom), 8'($urandom));
		test_random_traffic(60);
		test_backpressure();
		test_full_rate(120);

		// drain, then a few quiet cycles to catch stray result beats
		idle_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
